// ===== hdl/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared widths, register indexes and sideband types for the ray versus
// sphere intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

    // fixed-point format
    localparam int FRAC_BITS = 16;

    // port widths
    localparam int COORD_W   = 32;
    localparam int DIR_W     = 18;
    localparam int RSQ_W     = 31;
    localparam int T_W       = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQUARED = 2'd3;

    localparam logic [RSQ_W-1:0] RSQ_RESET = RSQ_W'(3 << FRAC_BITS);

    // l = center - origin, exact
    localparam int L_W    = COORD_W + 1;
    // l * dir and its three-term sum
    localparam int PROD_W = L_W + DIR_W;
    localparam int DOT_W  = PROD_W + 2;
    // l * l is at most 2^64, sum of three fits two more bits
    localparam int LSQ_W  = 2 * L_W - 1;
    localparam int LL_W   = LSQ_W + 2;

    // tca = floor(dot / 2^FRAC_BITS) and its magnitude split in two halves
    localparam int TCA_W  = DOT_W - FRAC_BITS;
    localparam int TMAG_W = TCA_W;
    localparam int TLO_W  = (TMAG_W + 1) / 2;
    localparam int THI_W  = TMAG_W - TLO_W;
    localparam int TCA2_W = 2 * TMAG_W;

    // radius_squared aligned to 2*FRAC_BITS fraction bits
    localparam int R2_W   = RSQ_W + FRAC_BITS;

    // discriminant, signed
    localparam int MAX_AB = (TCA2_W > LL_W) ? TCA2_W : LL_W;
    localparam int MAX_W  = (MAX_AB > R2_W) ? MAX_AB : R2_W;
    localparam int DIFF_W = MAX_W + 2;

    // square root unit: one result bit per stage
    localparam int ROOT_W = (DIFF_W + 1) / 2;
    localparam int REM_W  = 2 * ROOT_W + 1;

    // epsilon 0.0001 rounded to FRAC_BITS
    localparam int EPS_Q  = ((1 << FRAC_BITS) + 5000) / 10000;

    // distance sum width before saturation
    localparam int SUM_A  = (TCA_W > ROOT_W) ? TCA_W : ROOT_W;
    localparam int SUM_B  = (SUM_A > T_W) ? SUM_A : T_W;
    localparam int SUM_W  = SUM_B + 2;

    // data that rides along the square root stages
    typedef struct packed {
        logic                    hit;
        logic signed [TCA_W-1:0] tca;
    } rsi_side_t;

endpackage

// ===== hdl/ray_sphere_intersection.sv =====
// ----------------------------------------------------------------------------
// ray_sphere_intersection
// Tests one ray per cycle against a configured bounding sphere and returns
// the hit flag with the entry and exit distances.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  in      | sink      | in_valid / in_ready   | origin_x/y/z, dir_x/y/z
//  out     | source    | out_valid / out_ready | hit, t_near, t_far
//  cfg     | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One ray per cycle while the output is not stalled. The pipeline holds
// seven geometry stages, one stage per root bit, one output register.
// The depth is set by the bit-per-stage square root unit.
// Reset clears all valid bits and loads the register reset values.
// A stall at the output freezes the whole pipeline; in_ready falls while a
// transaction waits at the output and is not taken. cfg_ready is always high.
// ----------------------------------------------------------------------------
module ray_sphere_intersection
    import rsi_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic        [CFG_IDX_W-1:0] cfg_index,
    input  logic        [CFG_DAT_W-1:0] cfg_data,
    // rays
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [COORD_W-1:0]   origin_x,
    input  logic signed [COORD_W-1:0]   origin_y,
    input  logic signed [COORD_W-1:0]   origin_z,
    input  logic signed [DIR_W-1:0]     dir_x,
    input  logic signed [DIR_W-1:0]     dir_y,
    input  logic signed [DIR_W-1:0]     dir_z,
    // results
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        hit,
    output logic signed [T_W-1:0]       t_near,
    output logic signed [T_W-1:0]       t_far
);

    localparam logic signed [SUM_W-1:0] T_MAX = SUM_W'(2147483647);
    localparam logic signed [SUM_W-1:0] T_MIN = ~T_MAX;
    localparam logic signed [T_W-1:0]   T_MISS = {1'b1, {(T_W - 1){1'b0}}};

    // configuration registers
    logic signed [COORD_W-1:0] center_x_reg;
    logic signed [COORD_W-1:0] center_y_reg;
    logic signed [COORD_W-1:0] center_z_reg;
    logic        [RSQ_W-1:0]   rsq_reg;

    // pipeline control
    logic advance;

    // stage links
    logic              geo_valid;
    logic [REM_W-1:0]  geo_diff;
    rsi_side_t         geo_side;
    logic              root_valid;
    logic [ROOT_W-1:0] root;
    rsi_side_t         root_side;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic                 hit_reg, hit_next;
    logic signed [T_W-1:0] t_near_reg, t_near_next;
    logic signed [T_W-1:0] t_far_reg, t_far_next;
    logic signed [SUM_W-1:0] near_sum, far_sum;

    function automatic logic signed [T_W-1:0] sat_t(input logic signed [SUM_W-1:0] v);
        logic signed [T_W-1:0] r;
        if (v > T_MAX)
            r = T_MAX[T_W-1:0];
        else if (v < T_MIN)
            r = T_MIN[T_W-1:0];
        else
            r = v[T_W-1:0];
        return r;
    endfunction

    // register writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            rsq_reg      <= RSQ_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CENTER_X:       center_x_reg <= cfg_data;
                REG_CENTER_Y:       center_y_reg <= cfg_data;
                REG_CENTER_Z:       center_z_reg <= cfg_data;
                REG_RADIUS_SQUARED: rsq_reg      <= cfg_data[RSQ_W-1:0];
                default:            ;
            endcase
        end
    end

    // whole pipeline moves unless a result waits at the output and is not taken
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    rsi_geom u_geom (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .in_valid       (in_valid),
        .origin_x       (origin_x),
        .origin_y       (origin_y),
        .origin_z       (origin_z),
        .dir_x          (dir_x),
        .dir_y          (dir_y),
        .dir_z          (dir_z),
        .center_x       (center_x_reg),
        .center_y       (center_y_reg),
        .center_z       (center_z_reg),
        .radius_squared (rsq_reg),
        .geo_valid      (geo_valid),
        .geo_diff       (geo_diff),
        .geo_side       (geo_side)
    );

    rsi_sqrt u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .src_valid  (geo_valid),
        .src_rad    (geo_diff),
        .src_side   (geo_side),
        .root_valid (root_valid),
        .root       (root),
        .root_side  (root_side)
    );

    // distances with saturation, sentinel on miss
    always_comb
    begin
        near_sum       = SUM_W'(root_side.tca) - signed'(SUM_W'(root));
        far_sum        = SUM_W'(root_side.tca) + signed'(SUM_W'(root));
        out_valid_next = root_valid;
        hit_next       = root_side.hit;
        t_near_next    = root_side.hit ? sat_t(near_sum) : T_MISS;
        t_far_next     = root_side.hit ? sat_t(far_sum) : T_MISS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hit_reg    <= hit_next;
            t_near_reg <= t_near_next;
            t_far_reg  <= t_far_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign t_near    = t_near_reg;
    assign t_far     = t_far_reg;

endmodule

// ===== hdl/rsi_geom.sv =====
// ----------------------------------------------------------------------------
// rsi_geom
// Front end of the pipeline: l = center - origin, the dot products, tca,
// tca squared and the discriminant with its hit test (seven stages).
// ----------------------------------------------------------------------------
module rsi_geom
    import rsi_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic                      in_valid,
    input  logic signed [COORD_W-1:0] origin_x,
    input  logic signed [COORD_W-1:0] origin_y,
    input  logic signed [COORD_W-1:0] origin_z,
    input  logic signed [DIR_W-1:0]   dir_x,
    input  logic signed [DIR_W-1:0]   dir_y,
    input  logic signed [DIR_W-1:0]   dir_z,
    input  logic signed [COORD_W-1:0] center_x,
    input  logic signed [COORD_W-1:0] center_y,
    input  logic signed [COORD_W-1:0] center_z,
    input  logic        [RSQ_W-1:0]   radius_squared,
    output logic                      geo_valid,
    output logic        [REM_W-1:0]   geo_diff,
    output rsi_side_t                 geo_side
);

    localparam int NSTG = 7;
    localparam logic signed [DIFF_W-1:0] EPS_LIM = DIFF_W'(EPS_Q) <<< FRAC_BITS;

    // valid bits, one per stage
    logic [NSTG-1:0] vld_reg;

    // stage 1: l and direction
    logic signed [L_W-1:0]    l_reg    [3];
    logic signed [L_W-1:0]    l_next   [3];
    logic signed [DIR_W-1:0]  d_reg    [3];
    logic signed [COORD_W-1:0] org     [3];
    logic signed [COORD_W-1:0] ctr     [3];
    logic signed [DIR_W-1:0]  dir_in   [3];

    // stage 2: products
    logic signed [PROD_W-1:0] pd_reg   [3];
    logic signed [PROD_W-1:0] pd_next  [3];
    logic signed [2*L_W-1:0]  sq_full  [3];
    logic        [LSQ_W-1:0]  sq_reg   [3];
    logic        [LSQ_W-1:0]  sq_next  [3];

    // stage 3: sums
    logic signed [DOT_W-1:0]  dot_reg, dot_next;
    logic        [LL_W-1:0]   ll_reg, ll_next;

    // stage 4: tca, its magnitude, radius minus dot(l,l)
    logic signed [TCA_W-1:0]  tca4_reg, tca4_next;
    logic        [TMAG_W-1:0] tmag_reg, tmag_next;
    logic signed [DIFF_W-1:0] part4_reg, part4_next;
    logic        [R2_W-1:0]   r2;

    // stage 5: partial products of tca squared
    logic        [2*THI_W-1:0]       hh_reg, hh_next;
    logic        [THI_W+TLO_W-1:0]   hl_reg, hl_next;
    logic        [2*TLO_W-1:0]       lo_reg, lo_next;
    logic signed [TCA_W-1:0]  tca5_reg;
    logic signed [DIFF_W-1:0] part5_reg;

    // stage 6: tca squared
    logic        [TCA2_W-1:0] tca2_reg, tca2_next;
    logic signed [TCA_W-1:0]  tca6_reg;
    logic signed [DIFF_W-1:0] part6_reg;

    // stage 7: discriminant and hit test
    logic signed [DIFF_W-1:0] diff_c;
    logic        [REM_W-1:0]  diff_reg, diff_next;
    rsi_side_t                side_reg, side_next;

    assign org[0]    = origin_x;
    assign org[1]    = origin_y;
    assign org[2]    = origin_z;
    assign ctr[0]    = center_x;
    assign ctr[1]    = center_y;
    assign ctr[2]    = center_z;
    assign dir_in[0] = dir_x;
    assign dir_in[1] = dir_y;
    assign dir_in[2] = dir_z;

    // per-axis lanes: difference and both products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            l_next[i]  = L_W'(ctr[i]) - L_W'(org[i]);
            pd_next[i] = l_reg[i] * d_reg[i];
            sq_full[i] = l_reg[i] * l_reg[i];
            sq_next[i] = sq_full[i][LSQ_W-1:0];
        end
    end

    // three-term sums
    always_comb
    begin
        dot_next = DOT_W'(pd_reg[0]) + DOT_W'(pd_reg[1]) + DOT_W'(pd_reg[2]);
        ll_next  = LL_W'(sq_reg[0]) + LL_W'(sq_reg[1]) + LL_W'(sq_reg[2]);
    end

    // floor shift for tca, magnitude for the square
    always_comb
    begin
        r2         = {radius_squared, {FRAC_BITS{1'b0}}};
        tca4_next  = TCA_W'(dot_reg >>> FRAC_BITS);
        tmag_next  = tca4_next[TCA_W-1] ? TMAG_W'(-tca4_next) : TMAG_W'(tca4_next);
        part4_next = signed'(DIFF_W'(r2)) - signed'(DIFF_W'(ll_reg));
    end

    // tca squared from halves
    always_comb
    begin
        hh_next   = tmag_reg[TMAG_W-1:TLO_W] * tmag_reg[TMAG_W-1:TLO_W];
        hl_next   = tmag_reg[TMAG_W-1:TLO_W] * tmag_reg[TLO_W-1:0];
        lo_next   = tmag_reg[TLO_W-1:0] * tmag_reg[TLO_W-1:0];
        tca2_next = (TCA2_W'(hh_reg) << (2 * TLO_W))
                  + (TCA2_W'(hl_reg) << (TLO_W + 1))
                  + TCA2_W'(lo_reg);
    end

    // discriminant and epsilon test
    always_comb
    begin
        diff_c        = part6_reg + signed'(DIFF_W'(tca2_reg));
        diff_next     = {{(REM_W - DIFF_W){1'b0}}, diff_c};
        side_next.hit = !(diff_c < EPS_LIM);
        side_next.tca = tca6_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                l_reg[i]  <= l_next[i];
                d_reg[i]  <= dir_in[i];
                pd_reg[i] <= pd_next[i];
                sq_reg[i] <= sq_next[i];
            end
            dot_reg   <= dot_next;
            ll_reg    <= ll_next;
            tca4_reg  <= tca4_next;
            tmag_reg  <= tmag_next;
            part4_reg <= part4_next;
            hh_reg    <= hh_next;
            hl_reg    <= hl_next;
            lo_reg    <= lo_next;
            tca5_reg  <= tca4_reg;
            part5_reg <= part4_reg;
            tca2_reg  <= tca2_next;
            tca6_reg  <= tca5_reg;
            part6_reg <= part5_reg;
            diff_reg  <= diff_next;
            side_reg  <= side_next;
        end
    end

    assign geo_valid = vld_reg[NSTG-1];
    assign geo_diff  = diff_reg;
    assign geo_side  = side_reg;

endmodule

// ===== hdl/rsi_sqrt.sv =====
// ----------------------------------------------------------------------------
// rsi_sqrt
// Pipelined floor square root, one result bit per stage, restoring form
// with a running remainder. Sideband data travels alongside.
// ----------------------------------------------------------------------------
module rsi_sqrt
    import rsi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              src_valid,
    input  logic [REM_W-1:0]  src_rad,
    input  rsi_side_t         src_side,
    output logic              root_valid,
    output logic [ROOT_W-1:0] root,
    output rsi_side_t         root_side
);

    // stage k decides result bit ROOT_W-1-k
    logic              vld_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    rsi_side_t         side_reg [ROOT_W];

    logic              vld_in   [ROOT_W];
    logic [REM_W-1:0]  rem_in   [ROOT_W];
    logic [ROOT_W-1:0] root_in  [ROOT_W];
    rsi_side_t         side_in  [ROOT_W];

    assign vld_in[0]  = src_valid;
    assign rem_in[0]  = src_rad;
    assign root_in[0] = '0;
    assign side_in[0] = src_side;

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        localparam int BIT = ROOT_W - 1 - k;

        logic [REM_W-1:0]  trial;
        logic              take;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (k > 0)
        begin : g_link
            assign vld_in[k]  = vld_reg[k-1];
            assign rem_in[k]  = rem_reg[k-1];
            assign root_in[k] = root_reg[k-1];
            assign side_in[k] = side_reg[k-1];
        end

        // trial = 2*root*2^BIT + 2^(2*BIT)
        always_comb
        begin
            trial     = (REM_W'(root_in[k]) << (BIT + 1)) + (REM_W'(1) << (2 * BIT));
            take      = (trial <= rem_in[k]);
            rem_next  = take ? (rem_in[k] - trial) : rem_in[k];
            root_next = take ? (root_in[k] | (ROOT_W'(1) << BIT)) : root_in[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                vld_reg[k] <= vld_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_in[k];
            end
        end
    end

    assign root_valid = vld_reg[ROOT_W-1];
    assign root       = root_reg[ROOT_W-1];
    assign root_side  = side_reg[ROOT_W-1];

endmodule
